[src/text_console_char_writer_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the text console character writer
// Shared concurrent assertion forms; each use stands on a line of its own.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CHAR_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_CHAR_WRITER_ASSERT_SVH

// Check that a consequent holds in the same cycle as its antecedent.
`define TCW_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tcw: same-cycle check failed");

// Check that a consequent holds in the cycle after its antecedent.
`define TCW_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tcw: next-cycle check failed");

`endif

[src/tcw_pkg.sv]
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared widths and controller/datapath interface types of the text console.
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

   // Field widths of the stream payloads
   localparam int CHAR_W      = 8;
   localparam int ATTR_W      = 8;
   localparam int CELL_W      = 16;
   localparam int ROW_FIELD_W = 5;
   localparam int COL_FIELD_W = 7;
   localparam int REQ_DATA_W  = 32;
   localparam int RSP_DATA_W  = 32;

   // Blank attribute after reset
   localparam logic [ATTR_W-1:0] BLANK_ATTR_RESET = 8'd7;

   // Request actions carried in req_tuser
   localparam logic ACT_PUT  = 1'b0;
   localparam logic ACT_READ = 1'b1;

   // Control characters and the blank character
   localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
   localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
   localparam logic [CHAR_W-1:0] CH_FORMFEED  = 8'd12;
   localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;
   localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;

   // Controller to datapath commands
   typedef struct packed {
      logic exec;         // accept and execute the item on the request bus
      logic clear_step;   // write one zero cell of the post-reset clear sweep
      logic scroll_step;  // blank one cell of the row that becomes the bottom row
      logic emit;         // load the response register
   } tcw_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic need_scroll;  // item on the request bus moves past the last row
      logic clear_last;   // clear sweep is at its last cell
      logic scroll_last;  // scroll sweep is at its last column
   } tcw_status_type;

endpackage

`default_nettype wire

[src/tcw_ctrl.sv]
// ----------------------------------------------------------------------------
// tcw_ctrl
// Sequencer of the text console: clear sweep, item execution, scroll sweep
// and response handoff.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_ctrl (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_tvalid,
   output logic                    req_tready,
   output logic                    rsp_tvalid,
   input  wire                     rsp_tready,
   output tcw_pkg::tcw_cmd_type    cmd,
   input  tcw_pkg::tcw_status_type status
);
   import tcw_pkg::*;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCROLL,
      ST_EMIT
   } state_type;

   state_type state_ff;
   logic      req_tready_ff;
   logic      rsp_tvalid_ff;

   // Decode commands from the state
   always_comb begin
      cmd.exec        = req_tready_ff && req_tvalid;
      cmd.clear_step  = (state_ff == ST_CLEAR);
      cmd.scroll_step = (state_ff == ST_SCROLL);
      cmd.emit        = (state_ff == ST_EMIT) && (!rsp_tvalid_ff || rsp_tready);
   end

   // Advance the state and the handshake flags
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         req_tready_ff <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         if (rsp_tvalid_ff && rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_CLEAR: begin
               if (status.clear_last) begin
                  state_ff      <= ST_IDLE;
                  req_tready_ff <= 1'b1;
               end
            end
            ST_IDLE: begin
               if (cmd.exec) begin
                  req_tready_ff <= 1'b0;
                  state_ff      <= status.need_scroll ? ST_SCROLL : ST_EMIT;
               end
            end
            ST_SCROLL: begin
               if (status.scroll_last) begin
                  state_ff <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               if (cmd.emit) begin
                  rsp_tvalid_ff <= 1'b1;
                  req_tready_ff <= 1'b1;
                  state_ff      <= ST_IDLE;
               end
            end
         endcase
      end
   end

   assign req_tready = req_tready_ff;
   assign rsp_tvalid = rsp_tvalid_ff;

endmodule

`default_nettype wire

[src/tcw_datapath.sv]
// ----------------------------------------------------------------------------
// tcw_datapath
// Cell memory with a rotating top-row pointer, cursor registers, sweep
// counter, blank attribute register and the response register.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_datapath #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  wire                               clock,
   input  wire                               reset,
   input  tcw_pkg::tcw_cmd_type              cmd,
   output tcw_pkg::tcw_status_type           status,
   input  wire  [tcw_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  wire                               req_tuser,
   input  wire                               csr_wr_en,
   input  wire  [tcw_pkg::ATTR_W-1:0]        csr_wr_data,
   output logic [tcw_pkg::RSP_DATA_W-1:0]    rsp_tdata
);
   import tcw_pkg::*;

   localparam int CW       = $clog2(COLUMNS);
   localparam int RW       = $clog2(ROWS);
   localparam int DEPTH    = ROWS * COLUMNS;
   localparam int AW       = $clog2(DEPTH);
   localparam int PAD_W    = RSP_DATA_W - CELL_W - COL_FIELD_W - ROW_FIELD_W - 1;

   localparam logic [CW-1:0] LAST_COL = CW'(COLUMNS - 1);
   localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);
   localparam logic [RW:0]   ROWS_X   = (RW + 1)'(ROWS);

   typedef enum logic [2:0] {
      OP_READ,
      OP_LINE,
      OP_FEED,
      OP_BACK,
      OP_PRINT
   } op_type;

   // Map a screen row through the top-row pointer to a memory address
   function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] row,
                                               input logic [CW-1:0] col,
                                               input logic [RW-1:0] top);
      logic [RW:0] sum;
      logic [RW:0] phys;
      sum = {1'b0, row} + {1'b0, top};
      if (sum >= ROWS_X) begin
         phys = sum - ROWS_X;
      end else begin
         phys = sum;
      end
      return AW'(phys) * AW'(COLUMNS) + AW'(col);
   endfunction

   // Request fields
   logic [CHAR_W-1:0]      char_code;
   logic [ATTR_W-1:0]      colour;
   logic [ROW_FIELD_W-1:0] read_row;
   logic [COL_FIELD_W-1:0] read_col;

   assign char_code = req_tdata[7:0];
   assign colour    = req_tdata[15:8];
   assign read_row  = req_tdata[20:16];
   assign read_col  = req_tdata[27:21];

   // State
   logic [CELL_W-1:0] cell_mem_ff [DEPTH];
   logic [CW-1:0]     cx_ff, cx_in;
   logic [RW-1:0]     cy_ff, cy_in;
   logic [RW-1:0]     top_ff, top_in;
   logic [AW-1:0]     sweep_ff, sweep_in;
   logic [ATTR_W-1:0] blank_attr_ff;
   logic [CELL_W-1:0] rd_data_ff;
   logic              hit_ff;
   logic              scrolled_ff;
   logic [RSP_DATA_W-1:0] rsp_tdata_ff;

   // Combinational helpers
   op_type            op;
   logic              at_last_col, at_last_row, at_origin;
   logic [CW-1:0]     bs_col, pos_col;
   logic [RW-1:0]     bs_row, pos_row;
   logic [CELL_W-1:0] blank_cell;
   logic              rd_en, rd_hit;
   logic [AW-1:0]     rd_addr;
   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [CELL_W-1:0] wr_data;
   logic [CELL_W-1:0] cell_value;

   // Decode the item
   always_comb begin
      if (req_tuser == ACT_READ) begin
         op = OP_READ;
      end else begin
         case (char_code) inside
            CH_NEWLINE, CH_RETURN: op = OP_LINE;
            CH_FORMFEED:           op = OP_FEED;
            CH_BACKSPACE:          op = OP_BACK;
            default:               op = OP_PRINT;
         endcase
      end
   end

   assign at_last_col = (cx_ff == LAST_COL);
   assign at_last_row = (cy_ff == LAST_ROW);
   assign at_origin   = (cx_ff == '0) && (cy_ff == '0);
   assign blank_cell  = {blank_attr_ff, CH_SPACE};

   // Step back one cell, across a row boundary at column 0
   assign bs_row  = (cx_ff == '0) ? cy_ff - RW'(1) : cy_ff;
   assign bs_col  = (cx_ff == '0) ? LAST_COL : cx_ff - CW'(1);
   assign pos_row = (op == OP_BACK) ? bs_row : cy_ff;
   assign pos_col = (op == OP_BACK) ? bs_col : cx_ff;

   // Read port
   assign rd_hit  = (32'(read_row) < ROWS) && (32'(read_col) < COLUMNS);
   assign rd_en   = cmd.exec && (op == OP_READ);
   assign rd_addr = cell_addr(RW'(read_row), CW'(read_col), top_ff);

   // Execute the item, and step the sweeps
   always_comb begin
      cx_in    = cx_ff;
      cy_in    = cy_ff;
      top_in   = top_ff;
      sweep_in = sweep_ff;
      wr_en    = 1'b0;
      wr_addr  = cell_addr(pos_row, pos_col, top_ff);
      wr_data  = blank_cell;
      if (cmd.exec) begin
         case (op)
            OP_LINE: begin
               cx_in = '0;
               if (!at_last_row) begin
                  cy_in = cy_ff + RW'(1);
               end
            end
            OP_FEED: begin
               if (!at_last_row) begin
                  cy_in = cy_ff + RW'(1);
               end
            end
            OP_BACK: begin
               if (!at_origin) begin
                  cx_in = bs_col;
                  cy_in = bs_row;
                  wr_en = 1'b1;
               end
            end
            OP_PRINT: begin
               wr_en   = 1'b1;
               wr_data = {colour, char_code};
               if (at_last_col) begin
                  cx_in = '0;
                  if (!at_last_row) begin
                     cy_in = cy_ff + RW'(1);
                  end
               end else begin
                  cx_in = cx_ff + CW'(1);
               end
            end
            OP_READ: begin
            end
            default: begin
            end
         endcase
      end else if (cmd.clear_step) begin
         wr_en    = 1'b1;
         wr_addr  = sweep_ff;
         wr_data  = '0;
         sweep_in = status.clear_last ? '0 : sweep_ff + AW'(1);
      end else if (cmd.scroll_step) begin
         // The old top row becomes the new bottom row
         wr_en    = 1'b1;
         wr_addr  = AW'(top_ff) * AW'(COLUMNS) + sweep_ff;
         sweep_in = status.scroll_last ? '0 : sweep_ff + AW'(1);
         if (status.scroll_last) begin
            top_in = (top_ff == LAST_ROW) ? '0 : top_ff + RW'(1);
         end
      end
   end

   // Status toward the controller
   always_comb begin
      status.need_scroll = at_last_row &&
                           ((op == OP_LINE) || (op == OP_FEED) ||
                            ((op == OP_PRINT) && at_last_col));
      status.clear_last  = (sweep_ff == AW'(DEPTH - 1));
      status.scroll_last = (sweep_ff == AW'(COLUMNS - 1));
   end

   // Hold cursor, top pointer, sweep counter and blank attribute
   always_ff @(posedge clock) begin
      if (reset) begin
         cx_ff         <= '0;
         cy_ff         <= '0;
         top_ff        <= '0;
         sweep_ff      <= '0;
         blank_attr_ff <= BLANK_ATTR_RESET;
      end else begin
         cx_ff    <= cx_in;
         cy_ff    <= cy_in;
         top_ff   <= top_in;
         sweep_ff <= sweep_in;
         if (csr_wr_en) begin
            blank_attr_ff <= csr_wr_data;
         end
      end
   end

   // Cell memory: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         cell_mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= cell_mem_ff[rd_addr];
      end
   end

   // Capture per-item flags and load the response register
   assign cell_value = hit_ff ? rd_data_ff : '0;

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         hit_ff      <= (op == OP_READ) && rd_hit;
         scrolled_ff <= status.need_scroll;
      end
      if (cmd.emit) begin
         rsp_tdata_ff <= {PAD_W'(0), scrolled_ff, ROW_FIELD_W'(cy_ff),
                          COL_FIELD_W'(cx_ff), cell_value};
      end
   end

   assign rsp_tdata = rsp_tdata_ff;

endmodule

`default_nettype wire

[src/text_console_char_writer.sv]
// ----------------------------------------------------------------------------
// text_console_char_writer
// Character-cell text console of ROWS x COLUMNS 16-bit cells with cursor.
// ----------------------------------------------------------------------------
// Usage:
//   Request stream: req_tuser selects the action (0 put, 1 read a cell);
//   req_tdata carries the character, its attribute and the cell position to
//   read. Each request yields exactly one response transaction carrying the
//   cell read (zero for a put), the cursor after the item and a scroll flag.
//   csr_wr_en/csr_wr_data set the attribute of blank cells; write it only
//   while no transaction is in flight.
//   Flow: a taken request goes through the emit state, which loads the
//   response register; the next request is taken only after that. A scroll
//   first blanks each cell of the new bottom row through the single write
//   port of the cell memory; rows are not copied, a top-row pointer rotates.
//   Reset: the cursor goes to the origin, the blank attribute to 7, and a
//   clear sweep writes zero to all ROWS*COLUMNS cells while req_tready
//   stays low.
//   Stall: the response waits in its output register while rsp_tready is
//   low; the next request is taken but held from completing until the
//   register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_char_writer #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  wire                             clock,
   input  wire                             reset,
   // Request: tdata = char_code[7:0], colour[15:8], read_row[20:16],
   // read_col[27:21], zero[31:28]; tuser = action
   input  wire                             req_tvalid,
   output logic                            req_tready,
   input  wire  [tcw_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  wire                             req_tuser,
   // Response: tdata = cell_value[15:0], cursor_col[22:16],
   // cursor_row[27:23], scrolled[28], zero[31:29]
   output logic                            rsp_tvalid,
   input  wire                             rsp_tready,
   output logic [tcw_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // Blank attribute register
   input  wire                             csr_wr_en,
   input  wire  [tcw_pkg::ATTR_W-1:0]      csr_wr_data
);
   import tcw_pkg::*;

   tcw_cmd_type    cmd;
   tcw_status_type status;

   tcw_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   tcw_datapath #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_tdata   (rsp_tdata)
   );

endmodule

`default_nettype wire

[src/tcw_checker.sv]
// ----------------------------------------------------------------------------
// tcw_checker
// Port-level checks of the text console, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "text_console_char_writer_assert.svh"

module tcw_checker #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input wire                            clock,
   input wire                            reset,
   input wire                            req_tvalid,
   input wire                            req_tready,
   input wire                            rsp_tvalid,
   input wire                            rsp_tready,
   input wire [tcw_pkg::RSP_DATA_W-1:0]  rsp_tdata
);
   localparam logic [4:0] ROW_LAST5 = 5'(ROWS - 1);

   logic [15:0] rsp_cell;
   logic [6:0]  rsp_col;
   logic [4:0]  rsp_row;
   logic        rsp_scrolled;
   logic        rsp_wait;
   logic        scroll_ok;

   // Split the response fields
   assign rsp_cell     = rsp_tdata[15:0];
   assign rsp_col      = rsp_tdata[22:16];
   assign rsp_row      = rsp_tdata[27:23];
   assign rsp_scrolled = rsp_tdata[28];
   assign rsp_wait     = rsp_tvalid && !rsp_tready;
   assign scroll_ok    = (rsp_row == ROW_LAST5) && (rsp_cell == 16'd0);

   // A taken transaction closes the request side in the next cycle
   `TCW_ASSERT_NEXT(a_accept_gap, clock, reset, req_tvalid && req_tready, !req_tready)

   // A stalled response keeps its transaction
   `TCW_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_wait, rsp_tvalid && $stable(rsp_tdata))

   // The reported cursor column stays on the screen
   `TCW_ASSERT_IMPL(a_col_range, clock, reset, rsp_tvalid, 32'(rsp_col) < COLUMNS)

   // A scroll leaves the cursor on the last row and comes only from a put
   `TCW_ASSERT_IMPL(a_scroll_row, clock, reset, rsp_tvalid && rsp_scrolled, scroll_ok)

endmodule

bind text_console_char_writer tcw_checker #(
   .COLUMNS (COLUMNS),
   .ROWS    (ROWS)
) u_tcw_checker (
   .clock       (clock),
   .reset       (reset),
   .req_tvalid  (req_tvalid),
   .req_tready  (req_tready),
   .rsp_tvalid  (rsp_tvalid),
   .rsp_tready  (rsp_tready),
   .rsp_tdata   (rsp_tdata)
);

`default_nettype wire

[tb/sv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: text console character writer testbench
// Drives put and read transactions into the console with random gaps on the
// request side and random stalls on the response side. A model of the
// screen, cursor and blank attribute predicts every response, which is
// checked field by field in order. The blank attribute is rewritten between
// phases while the console is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
   import tcw_pkg::*;

   localparam int COLUMNS = 80;
   localparam int ROWS    = 25;
   localparam int LIMIT   = 600000;

   typedef struct packed {
      logic       action;
      logic [7:0] ch;
      logic [7:0] colour;
      logic [4:0] row;
      logic [6:0] col;
   } console_op_type;

   typedef struct packed {
      logic [15:0] cell_value;
      logic [6:0]  col;
      logic [4:0]  row;
      logic        scrolled;
   } console_rsp_type;

   localparam int OP_W = $bits(console_op_type);

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata   = '0;
   logic                  req_tuser   = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_wr_en   = 1'b0;
   logic [ATTR_W-1:0]     csr_wr_data = '0;

   text_console_char_writer #(
      .COLUMNS(COLUMNS),
      .ROWS   (ROWS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   // Screen model
   logic [15:0] screen_model [0:ROWS*COLUMNS-1];
   int          cur_col    = 0;
   int          cur_row    = 0;
   logic [7:0]  blank_attr = BLANK_ATTR_RESET;

   console_op_type  pending_ops [$];
   console_rsp_type expected_rsps [$];
   int              err_count   = 0;
   int              cycle_count = 0;
   bit              req_idle_on = 1'b1;
   bit              rsp_idle_on = 1'b1;

   initial begin
      for (int i = 0; i < ROWS*COLUMNS; i++) screen_model[i] = '0;
   end

   // Clock and reset
   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
   end

   // Move the cursor down a row; scroll the screen on the last row
   function automatic logic advance_row();
      if (cur_row >= ROWS-1) begin
         cur_row = ROWS-1;
         for (int i = 0; i < (ROWS-1)*COLUMNS; i++) screen_model[i] = screen_model[i+COLUMNS];
         for (int i = 0; i < COLUMNS; i++) screen_model[(ROWS-1)*COLUMNS+i] = {blank_attr, CH_SPACE};
         return 1'b1;
      end
      cur_row++;
      return 1'b0;
   endfunction

   // Apply one transaction to the screen model and return its response
   function automatic console_rsp_type console_apply(input console_op_type op);
      console_rsp_type r;
      r = '0;
      if (op.action == ACT_READ) begin
         if (op.row < ROWS && op.col < COLUMNS)
            r.cell_value = screen_model[op.row*COLUMNS + op.col];
      end else if (op.ch == CH_NEWLINE || op.ch == CH_RETURN) begin
         r.scrolled = advance_row();
         cur_col = 0;
      end else if (op.ch == CH_FORMFEED) begin
         r.scrolled = advance_row();
      end else if (op.ch == CH_BACKSPACE) begin
         if (cur_col != 0 || cur_row != 0) begin
            if (cur_col == 0) begin
               cur_row--;
               cur_col = COLUMNS-1;
            end else begin
               cur_col--;
            end
            screen_model[cur_row*COLUMNS + cur_col] = {blank_attr, CH_SPACE};
         end
      end else begin
         screen_model[cur_row*COLUMNS + cur_col] = {op.colour, op.ch};
         cur_col++;
         if (cur_col >= COLUMNS) begin
            cur_col = 0;
            r.scrolled = advance_row();
         end
      end
      r.col = cur_col[6:0];
      r.row = cur_row[4:0];
      return r;
   endfunction

   // Gap length: mostly none or short, a few long
   function automatic int pick_gap();
      int k;
      k = $urandom_range(0, 99);
      if (k < 55) return 0;
      if (k < 85) return $urandom_range(1, 3);
      if (k < 95) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic console_op_type mk_put(input logic [7:0] ch);
      console_op_type op;
      op.action = ACT_PUT;
      op.ch     = ch;
      op.colour = 8'($urandom);
      op.row    = 5'($urandom);
      op.col    = 7'($urandom);
      return op;
   endfunction

   function automatic console_op_type mk_read(input logic [4:0] row, input logic [6:0] col);
      console_op_type op;
      op.action = ACT_READ;
      op.ch     = 8'($urandom);
      op.colour = 8'($urandom);
      op.row    = row;
      op.col    = col;
      return op;
   endfunction

   function automatic console_op_type mk_char(input logic [7:0] ch, input logic [7:0] colour);
      console_op_type op;
      op        = mk_put(ch);
      op.colour = colour;
      return op;
   endfunction

   function automatic logic [7:0] rand_printable();
      logic [7:0] c;
      c = 8'($urandom);
      while (c == CH_BACKSPACE || c == CH_NEWLINE || c == CH_FORMFEED || c == CH_RETURN)
         c = 8'($urandom);
      return c;
   endfunction

   // Request driver: hold each transaction until accepted, then predict it
   always @(posedge clock) begin : req_driver
      console_op_type op;
      logic           next_valid;
      int             gap_left;
      if (reset) begin
         req_tvalid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_tvalid && req_tready) expected_rsps.push_back(console_apply(op));
         if (req_tvalid && !req_tready) begin
            next_valid = 1'b1;
         end else if (gap_left > 0) begin
            gap_left--;
            next_valid = 1'b0;
         end else if (pending_ops.size() > 0) begin
            op = pending_ops.pop_front();
            req_tdata  <= {4'd0, op.col, op.row, op.colour, op.ch};
            req_tuser  <= op.action;
            next_valid = 1'b1;
            gap_left   = req_idle_on ? pick_gap() : 0;
         end else begin
            next_valid = 1'b0;
         end
         req_tvalid <= next_valid;
      end
   end

   // Response ready: random stalls
   always @(posedge clock) begin : rsp_stall
      int   stall_left;
      logic rdy;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else begin
         if (stall_left > 0) begin
            stall_left--;
            rdy = 1'b0;
         end else begin
            rdy = 1'b1;
            if (rsp_idle_on && $urandom_range(0, 99) < 30) stall_left = pick_gap();
         end
         rsp_tready <= rdy;
      end
   end

   // Response monitor: compare each transaction with the oldest prediction
   always @(posedge clock) begin : rsp_monitor
      console_rsp_type want;
      console_rsp_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.cell_value = rsp_tdata[15:0];
         got.col        = rsp_tdata[22:16];
         got.row        = rsp_tdata[27:23];
         got.scrolled   = rsp_tdata[28];
         if (expected_rsps.size() == 0) begin
            $display("%0t: response with none expected, tdata=%h", $time, rsp_tdata);
            err_count++;
         end else begin
            want = expected_rsps.pop_front();
            if (got.cell_value != want.cell_value) begin
               $display("%0t: cell_value expected %h actual %h", $time,
                        want.cell_value, got.cell_value);
               err_count++;
            end
            if (got.col != want.col) begin
               $display("%0t: cursor_col expected %0d actual %0d", $time, want.col, got.col);
               err_count++;
            end
            if (got.row != want.row) begin
               $display("%0t: cursor_row expected %0d actual %0d", $time, want.row, got.row);
               err_count++;
            end
            if (got.scrolled != want.scrolled) begin
               $display("%0t: scrolled expected %0d actual %0d", $time,
                        want.scrolled, got.scrolled);
               err_count++;
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= LIMIT) begin
         $display("text_console_char_writer: mismatch");
         $finish;
      end
   end

   // Wait until every transaction is sent and answered, then let the block settle
   task automatic drain();
      @(negedge clock);
      while (pending_ops.size() > 0 || req_tvalid || expected_rsps.size() > 0)
         @(negedge clock);
      repeat (COLUMNS + 20) @(negedge clock);
   endtask

   task automatic write_blank_attr(input logic [7:0] value);
      drain();
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      blank_attr = value;
   endtask

   task automatic queue_directed();
      // Backspace at the origin, then character extremes
      pending_ops.push_back(mk_put(CH_BACKSPACE));
      pending_ops.push_back(mk_read(5'd0, 7'd0));
      pending_ops.push_back(mk_char(8'h00, 8'hFF));
      pending_ops.push_back(mk_char(8'hFF, 8'h00));
      pending_ops.push_back(mk_char(8'h41, 8'h5A));
      pending_ops.push_back(mk_read(5'd0, 7'd0));
      pending_ops.push_back(mk_read(5'd0, 7'd1));
      // Backspace within a row erases the cell
      pending_ops.push_back(mk_put(CH_BACKSPACE));
      pending_ops.push_back(mk_read(5'd0, 7'd2));
      // Return, then backspace across the row boundary
      pending_ops.push_back(mk_put(CH_RETURN));
      pending_ops.push_back(mk_put(CH_BACKSPACE));
      pending_ops.push_back(mk_read(5'd0, 7'd79));
      pending_ops.push_back(mk_char(8'h5A, 8'hC3));
      pending_ops.push_back(mk_read(5'd0, 7'd79));
      // Form feed keeps the column, newline returns to column 0
      pending_ops.push_back(mk_put(CH_FORMFEED));
      pending_ops.push_back(mk_char(8'h78, 8'h1E));
      pending_ops.push_back(mk_put(CH_FORMFEED));
      pending_ops.push_back(mk_put(CH_NEWLINE));
      // Reads at and beyond the screen edges
      pending_ops.push_back(mk_read(5'd31, 7'd127));
      pending_ops.push_back(mk_read(5'd25, 7'd0));
      pending_ops.push_back(mk_read(5'd24, 7'd80));
      pending_ops.push_back(mk_read(5'd24, 7'd79));
      pending_ops.push_back(mk_read(5'd0, 7'd127));
   endtask

   // Random part: mostly runs of text and control codes, with reads and noise
   task automatic queue_random(input int count);
      int             added;
      int             k;
      int             len;
      console_op_type op;
      logic [4:0]     r;
      logic [6:0]     c;
      added = 0;
      while (added < count) begin
         k = $urandom_range(0, 99);
         if (k < 40) begin
            len = $urandom_range(1, 90);
            if (len > count - added) len = count - added;
            repeat (len) pending_ops.push_back(mk_put(rand_printable()));
         end else if (k < 55) begin
            len = $urandom_range(1, 4);
            repeat (len) begin
               case ($urandom_range(0, 2))
                  0: pending_ops.push_back(mk_put(CH_NEWLINE));
                  1: pending_ops.push_back(mk_put(CH_RETURN));
                  default: pending_ops.push_back(mk_put(CH_FORMFEED));
               endcase
            end
         end else if (k < 65) begin
            len = $urandom_range(1, 6);
            repeat (len) pending_ops.push_back(mk_put(CH_BACKSPACE));
         end else if (k < 85) begin
            len = $urandom_range(1, 4);
            repeat (len) begin
               r = ($urandom_range(0, 2) == 0) ? 5'(ROWS-1) : 5'($urandom_range(0, ROWS-1));
               c = 7'($urandom_range(0, COLUMNS-1));
               pending_ops.push_back(mk_read(r, c));
            end
         end else if (k < 92) begin
            len = 1;
            r = 5'($urandom);
            c = 7'($urandom);
            if ($urandom_range(0, 1)) r = 5'($urandom_range(ROWS, 31));
            else c = 7'($urandom_range(COLUMNS, 127));
            pending_ops.push_back(mk_read(r, c));
         end else begin
            len = 1;
            op = OP_W'($urandom);
            pending_ops.push_back(op);
         end
         added += len;
      end
   endtask

   // Phases: rewrite the blank attribute between them while idle
   initial begin
      @(negedge clock);
      while (reset || !req_tready) @(negedge clock);

      write_blank_attr(8'h00);
      queue_directed();

      write_blank_attr(8'hFF);
      queue_random(120);

      write_blank_attr(8'h80);
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      queue_random(120);

      write_blank_attr(8'h3C);
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      queue_random(120);

      write_blank_attr(8'h07);
      queue_random(120);

      write_blank_attr(8'hA5);
      queue_random(120);

      drain();
      if (err_count == 0) begin
         $display("text_console_char_writer: match");
      end else begin
         $display("text_console_char_writer: mismatch");
      end
      $finish;
   end

endmodule
